FILE: hw/rtl/bsplk_pkg.sv
`timescale 1ns / 1ps

package bsplk_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned MAX_STEPS_DEF     = 64;

  localparam int unsigned CNT_W   = 11;
  localparam int unsigned FIELD_W = 10;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned PROD_W  = NORM_W + COORD_W;
  localparam int unsigned ACC_W   = PROD_W + 4;
  localparam int unsigned OFF_SHIFT = 14;

  typedef enum logic [1:0] {
    CMD_SPLIT = 2'd0,
    CMD_LEAF  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_WRITE = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_MX,
    S_MY,
    S_MZ,
    S_CMP,
    S_LEAF,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] z;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] x;
  } normal_t;

  typedef struct packed {
    logic        [FIELD_W-1:0] leaf_number;
    logic        [FIELD_W-1:0] back_child;
    logic        [FIELD_W-1:0] front_child;
    logic signed [COORD_W-1:0] plane_offset;
  } link_t;

  typedef struct packed {
    logic  start;
    logic  accum;
    axis_t sel;
  } mac_ctl_t;

  // entry index modulo the table depth, one conditional subtract per bit
  function automatic logic [FIELD_W-1:0] wrap_entry(input logic [FIELD_W-1:0] v,
                                                    input int unsigned depth);
    logic [31:0] r;
    logic [31:0] m;
    r = 32'(v);
    for (int k = FIELD_W - 1; k >= 0; k--) begin
      m = depth << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[FIELD_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/bsplk_in_if.sv
`timescale 1ns / 1ps

interface bsplk_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         entry_index;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [23:0] plane_offset;
  logic [9:0]         front_child;
  logic [9:0]         back_child;
  logic [9:0]         leaf_number;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;

  modport source (
    output valid, command, entry_index, normal_x, normal_y, normal_z, plane_offset,
           front_child, back_child, leaf_number, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, normal_x, normal_y, normal_z, plane_offset,
           front_child, back_child, leaf_number, point_x, point_y, point_z,
    output ready
  );
endinterface

FILE: hw/rtl/bsplk_out_if.sv
`timescale 1ns / 1ps

interface bsplk_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] found_leaf;
  logic [1:0] status;

  modport source (
    output valid, found_leaf, status,
    input  ready
  );

  modport sink (
    input  valid, found_leaf, status,
    output ready
  );
endinterface

FILE: hw/rtl/bsplk_table.sv
`timescale 1ns / 1ps

module bsplk_table #(
  parameter int unsigned DEPTH = bsplk_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                norm_we,
  input  logic                link_we,
  input  logic [AW-1:0]       wr_addr,
  input  bsplk_pkg::normal_t  norm_wd,
  input  bsplk_pkg::link_t    link_wd,
  input  logic [AW-1:0]       rd_addr,
  output bsplk_pkg::normal_t  norm_rd,
  output bsplk_pkg::link_t    link_rd
);
  import bsplk_pkg::*;

  normal_t norm_mem [DEPTH];
  link_t   link_mem [DEPTH];
  normal_t norm_rd_r;
  link_t   link_rd_r;

  always_ff @(posedge clk) begin
    if (norm_we) begin
      norm_mem[wr_addr] <= norm_wd;
    end
    norm_rd_r <= norm_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    link_rd_r <= link_mem[rd_addr];
  end

  assign norm_rd = norm_rd_r;
  assign link_rd = link_rd_r;

endmodule

FILE: hw/rtl/bsplk_mac.sv
`timescale 1ns / 1ps

module bsplk_mac (
  input  logic                                 clk,
  input  bsplk_pkg::mac_ctl_t                  ctl,
  input  bsplk_pkg::normal_t                   normal,
  input  logic signed [bsplk_pkg::COORD_W-1:0] plane_offset,
  input  logic signed [bsplk_pkg::COORD_W-1:0] px,
  input  logic signed [bsplk_pkg::COORD_W-1:0] py,
  input  logic signed [bsplk_pkg::COORD_W-1:0] pz,
  output logic                                 in_front
);
  import bsplk_pkg::*;

  logic signed [NORM_W-1:0]  n_sel;
  logic signed [COORD_W-1:0] p_sel;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   total;

  always_comb begin
    case (ctl.sel)
      AX_X: begin
        n_sel = normal.x;
        p_sel = px;
      end
      AX_Y: begin
        n_sel = normal.y;
        p_sel = py;
      end
      AX_Z: begin
        n_sel = normal.z;
        p_sel = pz;
      end
      default: begin
        n_sel = '0;
        p_sel = '0;
      end
    endcase
  end

  // one shared 16x24 multiplier, product registered before the add
  always_comb begin
    prod_nxt = PROD_W'(n_sel) * PROD_W'(p_sel);
    acc_nxt  = acc_r;
    if (ctl.start) begin
      acc_nxt = -(ACC_W'(plane_offset) <<< OFF_SHIFT);
    end else if (ctl.accum) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign total    = acc_r + ACC_W'(prod_r);
  assign in_front = (total > 0);

endmodule

FILE: hw/rtl/bsp_point_leaf_lookup.sv
`timescale 1ns / 1ps
// write commands: the sequencer goes straight to S_FIN, which loads the result word
// query: each plane test steps S_CHK, S_MX, S_MY, S_MZ, S_CMP; a leaf goes S_CHK, S_LEAF, S_FIN;
//   step limit: S_FIN after MAX_STEPS tests (one table read, three multiplier passes a level)
// one word in flight; a stalled result holds the sequencer in S_FIN; ready returns with the result loaded
// synchronous active-low reset clears the sequencer, output valid and the node count;
//   table contents are not cleared

module bsp_point_leaf_lookup #(
  parameter int unsigned TABLE_ENTRIES = bsplk_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_STEPS     = bsplk_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bsplk_pkg::CNT_W-1:0]   cfg_wdata,
  bsplk_in_if.sink                      in_if,
  bsplk_out_if.source                   out_if
);
  import bsplk_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW   = $clog2(MAX_STEPS + 1);
  localparam int unsigned CMPW = (AW > CNT_W) ? AW : CNT_W;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [SW-1:0]             steps_r, steps_nxt;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic [FIELD_W-1:0]        res_leaf_r, res_leaf_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]        out_leaf_r, out_leaf_nxt;
  status_t                   out_status_r, out_status_nxt;

  logic                      accept;
  logic                      norm_we, link_we;
  logic [AW-1:0]             wr_addr;
  normal_t                   norm_wd;
  link_t                     link_wd;
  normal_t                   norm_rd;
  link_t                     link_rd;
  mac_ctl_t                  mac_ctl;
  logic                      in_front;
  logic                      is_split;
  logic [31:0]               wr_wide, child_wide;
  logic [FIELD_W-1:0]        child;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  assign wr_wide  = 32'(wrap_entry(in_if.entry_index, TABLE_ENTRIES));
  assign wr_addr  = wr_wide[AW-1:0];
  assign norm_wd  = '{z: in_if.normal_z, y: in_if.normal_y, x: in_if.normal_x};

  always_comb begin
    link_wd = '0;
    norm_we = 1'b0;
    link_we = 1'b0;
    if (accept) begin
      case (cmd_t'(in_if.command))
        CMD_SPLIT: begin
          norm_we              = 1'b1;
          link_we              = 1'b1;
          link_wd.plane_offset = in_if.plane_offset;
          link_wd.front_child  = in_if.front_child;
          link_wd.back_child   = in_if.back_child;
        end
        CMD_LEAF: begin
          link_we             = 1'b1;
          link_wd.leaf_number = in_if.leaf_number;
        end
        default: begin
        end
      endcase
    end
  end

  bsplk_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .norm_we (norm_we),
    .link_we (link_we),
    .wr_addr (wr_addr),
    .norm_wd (norm_wd),
    .link_wd (link_wd),
    .rd_addr (idx_r),
    .norm_rd (norm_rd),
    .link_rd (link_rd)
  );

  bsplk_mac u_mac (
    .clk          (clk),
    .ctl          (mac_ctl),
    .normal       (norm_rd),
    .plane_offset (link_rd.plane_offset),
    .px           (px_r),
    .py           (py_r),
    .pz           (pz_r),
    .in_front     (in_front)
  );

  assign is_split   = (CMPW'(idx_r) < CMPW'(count_r));
  assign child      = in_front ? link_rd.front_child : link_rd.back_child;
  assign child_wide = 32'(wrap_entry(child, TABLE_ENTRIES));

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    res_leaf_nxt   = res_leaf_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_leaf_nxt   = out_leaf_r;
    out_status_nxt = out_status_r;
    mac_ctl        = '{start: 1'b0, accum: 1'b0, sel: AX_X};

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_leaf_nxt   = '0;
          res_status_nxt = ST_WRITE;
          if (cmd_t'(in_if.command) == CMD_QUERY) begin
            idx_nxt   = '0;
            steps_nxt = '0;
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CHK: begin
        if (!is_split) begin
          state_nxt = S_LEAF;
        end else if (steps_r == SW'(MAX_STEPS)) begin
          res_leaf_nxt   = '0;
          res_status_nxt = ST_LIMIT;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        mac_ctl   = '{start: 1'b1, accum: 1'b0, sel: AX_X};
        state_nxt = S_MY;
      end
      S_MY: begin
        mac_ctl   = '{start: 1'b0, accum: 1'b1, sel: AX_Y};
        state_nxt = S_MZ;
      end
      S_MZ: begin
        mac_ctl   = '{start: 1'b0, accum: 1'b1, sel: AX_Z};
        state_nxt = S_CMP;
      end
      S_CMP: begin
        idx_nxt   = child_wide[AW-1:0];
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_CHK;
      end
      S_LEAF: begin
        res_leaf_nxt   = link_rd.leaf_number;
        res_status_nxt = ST_DONE;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_leaf_nxt   = res_leaf_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    steps_r      <= steps_nxt;
    res_leaf_r   <= res_leaf_nxt;
    res_status_r <= res_status_nxt;
    out_leaf_r   <= out_leaf_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      px_r <= in_if.point_x;
      py_r <= in_if.point_y;
      pz_r <= in_if.point_z;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.found_leaf = out_leaf_r;
  assign out_if.status     = out_status_r;

endmodule

FILE: hw/rtl/bsplk_checker.sv
`timescale 1ns / 1ps

module bsplk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_found_leaf,
  input logic [1:0] out_status
);
  import bsplk_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_found_leaf) && $stable(out_status)))
    else $error("result word changed while stalled");

  // writes and over-long walks carry no leaf
  a_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_WRITE || out_status == ST_LIMIT)) |-> (out_found_leaf == '0))
    else $error("non-query result carries a leaf number");

  // one word at a time: ready drops after every acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  // a new result only appears after the block has been busy
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result produced without a word in flight");

endmodule

bind bsp_point_leaf_lookup bsplk_checker u_bsplk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_found_leaf (out_if.found_leaf),
  .out_status     (out_if.status)
);
